// ===== hw/rtl/elg_pkg.sv =====
`default_nettype none
package elg_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam int ADDR_BITS = 4;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PUBLIC_KEY = 2'd2;
    localparam logic [1:0] REG_PRIVATE_KEY = 2'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [WORD_BITS-1:0] ephemeral_exponent;
        logic [WORD_BITS-1:0] data_value;
        logic [WORD_BITS-1:0] shared_key_in;
    } req_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] result_value;
        logic [WORD_BITS-1:0] shared_key_out;
        logic                 inverse_missing;
    } rsp_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] generator;
        logic [WORD_BITS-1:0] public_key;
        logic [WORD_BITS-1:0] private_key;
    } cfg_regs_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] m;
        logic                 cin;
        logic                 sub;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] y;
        logic                 wrap;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/elg_alu.sv =====
`default_nettype none
module elg_alu (
    input  elg_pkg::alu_req_t req,
    output elg_pkg::alu_rsp_t rsp
);
    import elg_pkg::*;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] sum_red;
    logic [WORD_BITS-1:0] diff;

    // add: (a + b + cin) mod m for a, b below m; sub: (a - b) mod m
    always_comb
    begin
        sum = {2'b00, req.a} + {2'b00, req.b} + {{(WORD_BITS+1){1'b0}}, req.cin};
        sum_red = sum - {2'b00, req.m};
        diff = req.a - req.b;
        if (req.sub)
        begin
            rsp.wrap = (req.a >= req.b);
            rsp.y = rsp.wrap ? diff : diff + req.m;
        end
        else
        begin
            rsp.wrap = (sum >= {2'b00, req.m});
            rsp.y = rsp.wrap ? sum_red[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/elg_cfg.sv =====
`default_nettype none
module elg_cfg (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [elg_pkg::ADDR_BITS-1:0]    paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output elg_pkg::cfg_regs_t               regs
);
    import elg_pkg::*;

    cfg_regs_t regs_reg;
    logic      wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.modulus <= WORD_BITS'(3);
            regs_reg.generator <= WORD_BITS'(2);
            regs_reg.public_key <= WORD_BITS'(1);
            regs_reg.private_key <= WORD_BITS'(1);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MODULUS: regs_reg.modulus <= pwdata;
                REG_GENERATOR: regs_reg.generator <= pwdata;
                REG_PUBLIC_KEY: regs_reg.public_key <= pwdata;
                REG_PRIVATE_KEY: regs_reg.private_key <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODULUS: prdata = regs_reg.modulus;
            REG_GENERATOR: prdata = regs_reg.generator;
            REG_PUBLIC_KEY: prdata = regs_reg.public_key;
            REG_PRIVATE_KEY: prdata = regs_reg.private_key;
            default: prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/elg_seq.sv =====
`default_nettype none
module elg_seq (
    input  wire                    clk,
    input  wire                    rst_n,
    input  elg_pkg::cfg_regs_t     regs,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  elg_pkg::req_item_t     in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output elg_pkg::rsp_item_t     out_data,
    output elg_pkg::alu_req_t      alu_req,
    input  elg_pkg::alu_rsp_t      alu_rsp
);
    import elg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_DBL, S_MUL_ADD, S_NEXT, S_DIV_A, S_DIV_B, S_DIV_C,
        S_EUC_SUB, S_EUC_CHK, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ST_RED_DATA, ST_RED_BASE, ST_POW_SQ, ST_POW_ML, ST_FMUL
    } step_t;

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(WORD_BITS - 1);

    state_t               state_reg;
    step_t                step_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  ecnt_reg;
    logic                 op_reg;
    logic                 pass_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS-1:0] k_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] ke_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] exp_reg;
    logic [WORD_BITS-1:0] mask_reg;
    logic [WORD_BITS-1:0] mx_reg;
    logic [WORD_BITS-1:0] my_reg;
    logic [WORD_BITS-1:0] macc_reg;
    logic [WORD_BITS-1:0] r0_reg;
    logic [WORD_BITS-1:0] r1_reg;
    logic [WORD_BITS-1:0] t0_reg;
    logic [WORD_BITS-1:0] t1_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] dvd_reg;
    logic [WORD_BITS-1:0] qacc_reg;
    logic                 qbit_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] key_reg;
    logic                 miss_reg;
    logic [WORD_BITS-1:0] eff_mod;

    assign eff_mod = (regs.modulus < WORD_BITS'(3)) ? WORD_BITS'(3) : regs.modulus;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data.result_value = res_reg;
    assign out_data.shared_key_out = key_reg;
    assign out_data.inverse_missing = miss_reg;

    always_comb
    begin
        alu_req.a = macc_reg;
        alu_req.b = macc_reg;
        alu_req.m = m_reg;
        alu_req.cin = 1'b0;
        alu_req.sub = 1'b0;
        case (state_reg)
            S_MUL_ADD: alu_req.b = mx_reg;
            S_DIV_A:
            begin
                alu_req.a = rem_reg;
                alu_req.b = rem_reg;
                alu_req.cin = dvd_reg[WORD_BITS-1];
                alu_req.m = r1_reg;
            end
            S_DIV_B:
            begin
                alu_req.a = qacc_reg;
                alu_req.b = qacc_reg;
            end
            S_DIV_C:
            begin
                alu_req.a = qacc_reg;
                alu_req.b = t1_reg;
            end
            S_EUC_SUB:
            begin
                alu_req.a = t0_reg;
                alu_req.b = qacc_reg;
                alu_req.sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= ST_RED_DATA;
            cnt_reg <= '0;
            ecnt_reg <= '0;
            pass_reg <= 1'b0;
            miss_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        m_reg <= eff_mod;
                        op_reg <= in_data.op;
                        k_reg <= in_data.ephemeral_exponent;
                        ke_reg <= in_data.shared_key_in;
                        key_reg <= in_data.shared_key_in;
                        miss_reg <= 1'b0;
                        pass_reg <= 1'b0;
                        mx_reg <= ONE;
                        my_reg <= in_data.data_value;
                        macc_reg <= '0;
                        cnt_reg <= '0;
                        step_reg <= ST_RED_DATA;
                        state_reg <= S_MUL_DBL;
                    end
                end
                S_MUL_DBL:
                begin
                    macc_reg <= alu_rsp.y;
                    state_reg <= S_MUL_ADD;
                end
                S_MUL_ADD:
                begin
                    if (my_reg[WORD_BITS-1])
                    begin
                        macc_reg <= alu_rsp.y;
                    end
                    my_reg <= my_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg == LAST) ? S_NEXT : S_MUL_DBL;
                end
                S_NEXT:
                begin
                    cnt_reg <= '0;
                    case (step_reg)
                        ST_RED_DATA:
                        begin
                            data_reg <= macc_reg;
                            mx_reg <= ONE;
                            my_reg <= (op_reg == OP_DECRYPT) ? ke_reg : regs.public_key;
                            macc_reg <= '0;
                            step_reg <= ST_RED_BASE;
                            state_reg <= S_MUL_DBL;
                        end
                        ST_RED_BASE:
                        begin
                            base_reg <= macc_reg;
                            exp_reg <= (op_reg == OP_DECRYPT) ? regs.private_key : k_reg;
                            ecnt_reg <= '0;
                            mx_reg <= ONE;
                            my_reg <= ONE;
                            macc_reg <= '0;
                            step_reg <= ST_POW_SQ;
                            state_reg <= S_MUL_DBL;
                        end
                        ST_POW_SQ, ST_POW_ML:
                        begin
                            macc_reg <= '0;
                            if (step_reg == ST_POW_SQ && exp_reg[WORD_BITS-1])
                            begin
                                mx_reg <= macc_reg;
                                my_reg <= base_reg;
                                step_reg <= ST_POW_ML;
                                state_reg <= S_MUL_DBL;
                            end
                            else if (ecnt_reg != LAST)
                            begin
                                exp_reg <= exp_reg << 1;
                                ecnt_reg <= ecnt_reg + 1'b1;
                                mx_reg <= macc_reg;
                                my_reg <= macc_reg;
                                step_reg <= ST_POW_SQ;
                                state_reg <= S_MUL_DBL;
                            end
                            else if (op_reg == OP_DECRYPT)
                            begin
                                r0_reg <= m_reg;
                                r1_reg <= macc_reg;
                                t0_reg <= '0;
                                t1_reg <= ONE;
                                state_reg <= S_EUC_CHK;
                            end
                            else if (!pass_reg)
                            begin
                                mask_reg <= macc_reg;
                                pass_reg <= 1'b1;
                                mx_reg <= ONE;
                                my_reg <= regs.generator;
                                step_reg <= ST_RED_BASE;
                                state_reg <= S_MUL_DBL;
                            end
                            else
                            begin
                                key_reg <= macc_reg;
                                mx_reg <= mask_reg;
                                my_reg <= data_reg;
                                step_reg <= ST_FMUL;
                                state_reg <= S_MUL_DBL;
                            end
                        end
                        ST_FMUL:
                        begin
                            res_reg <= macc_reg;
                            state_reg <= S_DONE;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_DIV_A:
                begin
                    rem_reg <= alu_rsp.y;
                    qbit_reg <= alu_rsp.wrap;
                    dvd_reg <= dvd_reg << 1;
                    state_reg <= S_DIV_B;
                end
                S_DIV_B:
                begin
                    qacc_reg <= alu_rsp.y;
                    state_reg <= S_DIV_C;
                end
                S_DIV_C:
                begin
                    if (qbit_reg)
                    begin
                        qacc_reg <= alu_rsp.y;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg == LAST) ? S_EUC_SUB : S_DIV_A;
                end
                S_EUC_SUB:
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= rem_reg;
                    t0_reg <= t1_reg;
                    t1_reg <= alu_rsp.y;
                    state_reg <= S_EUC_CHK;
                end
                S_EUC_CHK:
                begin
                    cnt_reg <= '0;
                    if (r1_reg == '0)
                    begin
                        if (r0_reg == ONE)
                        begin
                            mx_reg <= t0_reg;
                            my_reg <= data_reg;
                            macc_reg <= '0;
                            step_reg <= ST_FMUL;
                            state_reg <= S_MUL_DBL;
                        end
                        else
                        begin
                            res_reg <= '0;
                            miss_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        rem_reg <= '0;
                        qacc_reg <= '0;
                        dvd_reg <= r0_reg;
                        state_reg <= S_DIV_A;
                    end
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/elgamal_encrypt_decrypt.sv =====
// elgamal encrypt / decrypt engine, modulus of up to 32 bits
// config: apb-style port, registers modulus, generator, public_key,
//   private_key at byte addresses 0, 4, 8, 12; pready is always high
// input channel in_valid / in_stall / in_data: op 0 encrypts
//   (ephemeral_exponent, data_value), op 1 decrypts (shared_key_in,
//   data_value); a transfer happens when valid is high and stall is low
// output channel out_valid / out_stall / out_data: one result per item
// one item at a time: in_stall is high from the transfer in until the
//   result transfer out
// every modular product is bit-serial on one shared add/sub unit: a double
//   step and an add step per multiplier bit, then a dispatch step
// encrypt: 3 + 64 + 2*popcount(k) + 1 products
// decrypt: 2 + 32 + popcount(d) + 1 products plus extended euclid, each
//   quotient by bit-serial division on the same unit
// reset: registers return to modulus 3, generator 2, keys 1, engine idle
// a stalled result holds in the output until the receiver takes it
`default_nettype none
module elgamal_encrypt_decrypt (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [elg_pkg::ADDR_BITS-1:0] paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  elg_pkg::req_item_t            in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output elg_pkg::rsp_item_t            out_data
);
    import elg_pkg::*;

    cfg_regs_t regs;
    alu_req_t  alu_req;
    alu_rsp_t  alu_rsp;

    elg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    elg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    elg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/elg_checker.sv =====
`default_nettype none
module elg_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input wire                out_valid,
    input wire                out_stall,
    input elg_pkg::rsp_item_t out_data
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // engine busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("engine not busy after input transfer");

    // no new item while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // missing inverse gives a zero result
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.inverse_missing |-> out_data.result_value == '0)
        else $error("nonzero result with missing inverse");

endmodule

bind elgamal_encrypt_decrypt elg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
